### rtl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg: shared types and codes for the positional ordered list
// Transfer structs, command and status codes, cell operations and the
// controller state encoding.
// ----------------------------------------------------------------------------
package pol_pkg;

   // Default sizing
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Command codes carried in the request cmd field
   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_INSERT_AT  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_DELETE_AT  = 3'd5,
      CMD_DUMP       = 3'd6
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   // What one cell does in a cycle
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_FROM_LEFT,
      OP_FROM_RIGHT,
      OP_WRAP
   } cell_op_type;

   // Edit decoded from one request
   typedef enum logic [1:0] {
      EK_NONE,
      EK_INSERT,
      EK_REMOVE,
      EK_DUMP
   } edit_kind_type;

   // Controller state, one-hot
   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_DUMP = 2'b10
   } fsm_type;

   // Request transfer
   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   // Result transfer
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic [4:0]         entry_count;
      logic               last;
   } rsp_type;

endpackage

### rtl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell: one slot of the list chain
// Holds one stored word and takes a new one from the request, from either
// neighbor or from the head of the chain, as the controller directs.
// ----------------------------------------------------------------------------
module pol_cell #(
   parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  pol_pkg::cell_op_type    op,
   input  logic [DATA_WIDTH-1:0]   load_word,
   input  logic [DATA_WIDTH-1:0]   left_word,
   input  logic [DATA_WIDTH-1:0]   right_word,
   input  logic [DATA_WIDTH-1:0]   wrap_word,
   output logic [DATA_WIDTH-1:0]   word
);
   import pol_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   // next word select
   always_comb begin
      case (op)
         OP_HOLD:       word_in = word_ff;
         OP_LOAD:       word_in = load_word;
         OP_FROM_LEFT:  word_in = left_word;
         OP_FROM_RIGHT: word_in = right_word;
         OP_WRAP:       word_in = wrap_word;
         default:       word_in = word_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### rtl/positional_ordered_list.sv
// Results: an edit or a single-result command has its result registered at the
//   request transfer; a dump enters the dump state, then registers each entry.
// Throughput: one command per cycle while results are taken; a dump blocks
//   new requests until every stored entry has been sent, as the chain rotates
//   the list past its head cell.
// Reset: synchronous; clears the entry count and controller, not the slots.
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list with positional edits
// A row of cells holds the entries front first; inserts and deletes shift
// the tail of the chain by one cell, all cells together, and a dump rotates the
// occupied cells through the head while emitting one result per entry.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
   parameter int DEPTH      = pol_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pol_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pol_pkg::rsp_type rsp_payload
);
   import pol_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);   // entry count width
   localparam int IW = $clog2(DEPTH);       // slot index width
   localparam int XW = ((CW > 5) ? CW : 5) + 1;

   // cell chain
   logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
   cell_op_type           cell_op [DEPTH];
   logic [DATA_WIDTH-1:0] load_word;

   // control registers
   fsm_type       state_ff, state_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [IW-1:0] dump_idx_ff, dump_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // decode
   logic          out_free;
   logic          req_fire;
   logic [XW-1:0] pos_x, occ_x;
   status_type    dec_status;
   edit_kind_type dec_kind;
   logic [IW-1:0] dec_at;
   edit_kind_type apply_kind;
   logic          dump_step;
   logic          dump_last;
   logic [31:0]   rem_word;
   logic [31:0]   head_word;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign pos_x     = XW'(req_payload.position);
   assign occ_x     = XW'(occ_ff);
   assign load_word = DATA_WIDTH'(req_payload.value);
   assign dump_step = (state_ff == FSM_DUMP) && out_free;
   assign dump_last = ((CW + 1)'(dump_idx_ff) + (CW + 1)'(1)) == (CW + 1)'(occ_ff);

   // stored word to result width: sign extend or keep the low 32 bits
   function automatic logic [31:0] fmt_word(input logic [DATA_WIDTH-1:0] w);
      logic signed [63:0] sx;
      sx = 64'(signed'(w));
      return sx[31:0];
   endfunction

   assign rem_word  = fmt_word(cell_q[dec_at]);
   assign head_word = fmt_word(cell_q[0]);

   // command decode: status, edit kind and target slot
   always_comb begin
      dec_status = ST_OK;
      dec_kind   = EK_NONE;
      dec_at     = '0;
      case (req_payload.cmd)
         CMD_PUSH_FRONT: begin
            if (occ_ff == CW'(DEPTH)) dec_status = ST_FULL;
            else dec_kind = EK_INSERT;
         end
         CMD_PUSH_BACK: begin
            if (occ_ff == CW'(DEPTH)) dec_status = ST_FULL;
            else begin
               dec_kind = EK_INSERT;
               dec_at   = IW'(occ_ff);
            end
         end
         CMD_INSERT_AT: begin
            if (occ_ff == CW'(DEPTH)) dec_status = ST_FULL;
            else if (pos_x == '0 || pos_x > occ_x + XW'(1)) dec_status = ST_BAD_POS;
            else begin
               dec_kind = EK_INSERT;
               dec_at   = IW'(pos_x - XW'(1));
            end
         end
         CMD_POP_FRONT: begin
            if (occ_ff == '0) dec_status = ST_EMPTY;
            else dec_kind = EK_REMOVE;
         end
         CMD_POP_BACK: begin
            if (occ_ff == '0) dec_status = ST_EMPTY;
            else begin
               dec_kind = EK_REMOVE;
               dec_at   = IW'(occ_x - XW'(1));
            end
         end
         CMD_DELETE_AT: begin
            if (occ_ff == '0) dec_status = ST_EMPTY;
            else if (pos_x == '0 || pos_x > occ_x) dec_status = ST_BAD_POS;
            else begin
               dec_kind = EK_REMOVE;
               dec_at   = IW'(pos_x - XW'(1));
            end
         end
         CMD_DUMP: begin
            if (occ_ff == '0) dec_status = ST_EMPTY;
            else dec_kind = EK_DUMP;
         end
         default: begin
            dec_kind = EK_NONE;
         end
      endcase
   end

   assign apply_kind = req_fire ? dec_kind : EK_NONE;

   // per-cell operation
   always_comb begin
      logic [CW:0] ix;
      logic [CW:0] at_x;
      logic [CW:0] oc_x;
      at_x = (CW + 1)'(dec_at);
      oc_x = (CW + 1)'(occ_ff);
      for (int i = 0; i < DEPTH; i++) begin
         ix         = (CW + 1)'(i);
         cell_op[i] = OP_HOLD;
         if (apply_kind == EK_INSERT) begin
            if (ix == at_x) cell_op[i] = OP_LOAD;
            else if (ix > at_x && ix <= oc_x) cell_op[i] = OP_FROM_LEFT;
         end else if (apply_kind == EK_REMOVE) begin
            if (ix >= at_x && ix + (CW + 1)'(1) < oc_x) cell_op[i] = OP_FROM_RIGHT;
         end else if (dump_step) begin
            if (ix + (CW + 1)'(1) < oc_x) cell_op[i] = OP_FROM_RIGHT;
            else if (ix + (CW + 1)'(1) == oc_x) cell_op[i] = OP_WRAP;
         end
      end
   end

   // cell row
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (g == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_body
         assign left_w = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_w = '0;
      end else begin : g_inner
         assign right_w = cell_q[g+1];
      end
      pol_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op[g]),
         .load_word  (load_word),
         .left_word  (left_w),
         .right_word (right_w),
         .wrap_word  (cell_q[0]),
         .word       (cell_q[g])
      );
   end

   // controller, count and result register next state
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               if (dec_kind == EK_INSERT) occ_in = occ_ff + CW'(1);
               else if (dec_kind == EK_REMOVE) occ_in = occ_ff - CW'(1);
               if (dec_kind == EK_DUMP) begin
                  state_in    = FSM_DUMP;
                  dump_idx_in = '0;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = dec_status;
                  rsp_in.data_out    = (dec_kind == EK_REMOVE) ? rem_word : '0;
                  rsp_in.entry_count = 5'(occ_in);
                  rsp_in.last        = 1'b1;
               end
            end
         end
         FSM_DUMP: begin
            if (dump_step) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = ST_OK;
               rsp_in.data_out    = head_word;
               rsp_in.entry_count = 5'(occ_ff);
               rsp_in.last        = dump_last;
               dump_idx_in        = dump_idx_ff + IW'(1);
               if (dump_last) state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         occ_ff       <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DUMP) |-> (occ_ff != '0))
      else $error("dump running on an empty list");

   a_dump_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DUMP) |-> ((CW + 1)'(dump_idx_ff) < (CW + 1)'(occ_ff)))
      else $error("dump index past last entry");

   a_occ_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(occ_ff))
      else $error("entry count changed without a request transfer");

endmodule

### tb/sv/positional_ordered_list_tb.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_tb: self-checking bench for the positional list
// Drives list commands over the request channel with random gaps. Each
// accepted command goes through a bench-side copy of the list, which queues
// the results it should cause. Every result transfer is compared field by
// field against the oldest queued result. A directed opening covers the
// empty, full and bad-position cases. Random traffic then fills and drains
// the list in waves, with some noise mixed in.
// ----------------------------------------------------------------------------
module positional_ordered_list_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pol_pkg::*;

   localparam int          DEPTH        = DEPTH_DEF;
   localparam int          RANDOM_ITEMS = 385;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [2:0]  CMD_UNUSED   = 3'd7;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   positional_ordered_list dut (clock, reset, req_valid, req_ready, req_payload,
                                rsp_valid, rsp_ready, rsp_payload);

   // Commands waiting to go out, results waiting to come back
   req_type pending_cmds[$];
   rsp_type expected_rsp[$];

   // Bench copy of the list contents
   logic signed [31:0] list_words [DEPTH];
   int                 list_fill = 0;

   int accepted_cmds = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   // Queue one result of the command being applied
   function automatic void note_rsp(input status_type st, input logic signed [31:0] word,
                                    input logic fin);
      rsp_type r;
      r.status      = st;
      r.data_out    = word;
      r.entry_count = list_fill[4:0];
      r.last        = fin;
      expected_rsp.push_back(r);
   endfunction

   // Put a word in at slot idx, shifting the tail back
   function automatic void list_insert(input int idx, input logic signed [31:0] word);
      for (int i = list_fill; i > idx; i--) list_words[i] = list_words[i - 1];
      list_words[idx] = word;
      list_fill++;
      note_rsp(ST_OK, '0, 1'b1);
   endfunction

   // Take the word out of slot idx, closing the gap
   function automatic void list_remove(input int idx);
      logic signed [31:0] word;
      word = list_words[idx];
      for (int i = idx; i + 1 < list_fill; i++) list_words[i] = list_words[i + 1];
      list_fill--;
      note_rsp(ST_OK, word, 1'b1);
   endfunction

   // Apply one accepted command to the bench list and queue its results
   function automatic void apply_command(input req_type r);
      int pos;
      pos = int'(r.position);
      case (r.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
            if (list_fill >= DEPTH) begin
               note_rsp(ST_FULL, '0, 1'b1);
            end else if (r.cmd == CMD_PUSH_FRONT) begin
               list_insert(0, r.value);
            end else if (r.cmd == CMD_PUSH_BACK) begin
               list_insert(list_fill, r.value);
            end else if (pos == 0 || pos > list_fill + 1) begin
               note_rsp(ST_BAD_POS, '0, 1'b1);
            end else begin
               list_insert(pos - 1, r.value);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE_AT: begin
            if (list_fill == 0) begin
               note_rsp(ST_EMPTY, '0, 1'b1);
            end else if (r.cmd == CMD_POP_FRONT) begin
               list_remove(0);
            end else if (r.cmd == CMD_POP_BACK) begin
               list_remove(list_fill - 1);
            end else if (pos == 0 || pos > list_fill) begin
               note_rsp(ST_BAD_POS, '0, 1'b1);
            end else begin
               list_remove(pos - 1);
            end
         end
         CMD_DUMP: begin
            if (list_fill == 0) begin
               note_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_fill; i++)
                  note_rsp(ST_OK, list_words[i], (i == list_fill - 1));
            end
         end
         default: begin
            note_rsp(ST_OK, '0, 1'b1);
         end
      endcase
   endfunction

   // Entry count a command leaves behind; steers the generator
   function automatic int fill_after(input req_type r, input int f);
      case (r.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: return (f < DEPTH) ? f + 1 : f;
         CMD_INSERT_AT:
            return (f < DEPTH && r.position >= 1 && r.position <= f + 1) ? f + 1 : f;
         CMD_POP_FRONT, CMD_POP_BACK: return (f > 0) ? f - 1 : f;
         CMD_DELETE_AT: return (f > 0 && r.position >= 1 && r.position <= f) ? f - 1 : f;
         default: return f;
      endcase
   endfunction

   // Driver: one command at a time, random gap after each transfer
   int  req_gap   = 0;
   bit  req_quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_command(req_payload);
            accepted_cmds <= accepted_cmds + 1;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (pending_cmds.size() > 0) begin
               if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
               req_valid   <= 1'b1;
               req_payload <= pending_cmds.pop_front();
               req_gap     <= draw_wait(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random stall after each result, check against the oldest expectation
   int  rsp_hold  = 0;
   bit  rsp_quiet = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      int      w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result: status %0d data %0d count %0d last %0d",
                        rsp_payload.status, rsp_payload.data_out,
                        rsp_payload.entry_count, rsp_payload.last);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_payload.status !== want.status || rsp_payload.data_out !== want.data_out ||
                rsp_payload.entry_count !== want.entry_count ||
                rsp_payload.last !== want.last) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display({"mismatch: exp status %0d data %0d count %0d last %0d,",
                            " got %0d %0d %0d %0d"},
                           want.status, want.data_out, want.entry_count, want.last,
                           rsp_payload.status, rsp_payload.data_out,
                           rsp_payload.entry_count, rsp_payload.last);
            end
         end
         if ($urandom_range(0, 29) == 0) rsp_quiet = !rsp_quiet;
         w = draw_wait(rsp_quiet);
         rsp_hold  <= w;
         rsp_ready <= (w == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus generation
   int plan_fill = 0;

   function automatic void queue_cmd(input logic [2:0] c, input logic signed [31:0] v,
                                     input int p);
      req_type r;
      r.cmd      = c;
      r.value    = v;
      r.position = p[4:0];
      pending_cmds.push_back(r);
      plan_fill = fill_after(r, plan_fill);
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                 total;
      int                 roll;
      int                 top;
      bit                 filling;
      logic signed [31:0] val;

      // Directed: empty list
      queue_cmd(CMD_POP_FRONT, 32'sd5, 1);
      queue_cmd(CMD_POP_BACK, 32'sd5, 1);
      queue_cmd(CMD_DELETE_AT, 32'sd5, 0);
      queue_cmd(CMD_DUMP, 32'sd5, 0);
      queue_cmd(CMD_INSERT_AT, 32'sd9, 0);
      queue_cmd(CMD_INSERT_AT, 32'sd9, 2);
      // Word extremes, positional insert at front, back and middle
      queue_cmd(CMD_INSERT_AT, 32'sh7fff_ffff, 1);
      queue_cmd(CMD_PUSH_FRONT, 32'sh8000_0000, 16);
      queue_cmd(CMD_PUSH_BACK, '0, 31);
      queue_cmd(CMD_PUSH_BACK, -32'sd1, 0);
      queue_cmd(CMD_INSERT_AT, 32'sh5555_aaaa, 5);
      queue_cmd(CMD_INSERT_AT, 32'sh0f0f_f0f0, 3);
      queue_cmd(CMD_UNUSED, 32'sh1234_5678, 16);
      // Positional deletes: bad positions, then back and front
      queue_cmd(CMD_DELETE_AT, '0, 0);
      queue_cmd(CMD_DELETE_AT, '0, 7);
      queue_cmd(CMD_DELETE_AT, '0, 6);
      queue_cmd(CMD_DELETE_AT, '0, 1);
      queue_cmd(CMD_DUMP, '0, 0);
      // Fill up, then push-front and insert-at against a full list
      while (plan_fill < DEPTH) queue_cmd(CMD_PUSH_BACK, $urandom, $urandom_range(0, 16));
      queue_cmd(CMD_PUSH_FRONT, 32'sd1, 1);
      queue_cmd(CMD_INSERT_AT, 32'sd1, 0);
      queue_cmd(CMD_INSERT_AT, 32'sd1, 16);
      queue_cmd(CMD_DUMP, '0, 0);
      queue_cmd(CMD_DELETE_AT, '0, 16);
      queue_cmd(CMD_POP_BACK, '0, 0);
      queue_cmd(CMD_POP_FRONT, '0, 0);

      // Random: fill and drain in waves, mostly well-formed
      filling = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (plan_fill == DEPTH) filling = 1'b0;
         else if (plan_fill == 0) filling = 1'b1;
         else if ($urandom_range(0, 39) == 0) filling = !filling;
         roll = $urandom_range(0, 99);
         val  = pick_word();
         if (roll < 2) begin
            queue_cmd(CMD_UNUSED, val, $urandom_range(0, 16));
         end else if (roll < 9) begin
            queue_cmd(CMD_DUMP, val, $urandom_range(0, 16));
         end else if (roll < 14) begin
            queue_cmd(3'($urandom_range(0, 7)), val, $urandom_range(0, 16));
         end else if ($urandom_range(0, 99) < (filling ? 75 : 25)) begin
            top = (plan_fill + 1 > DEPTH) ? DEPTH : plan_fill + 1;
            case ($urandom_range(0, 2))
               0: queue_cmd(CMD_PUSH_FRONT, val, $urandom_range(0, 16));
               1: queue_cmd(CMD_PUSH_BACK, val, $urandom_range(0, 16));
               default: queue_cmd(CMD_INSERT_AT, val, ($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, 16) : $urandom_range(1, top));
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0: queue_cmd(CMD_POP_FRONT, val, $urandom_range(0, 16));
               1: queue_cmd(CMD_POP_BACK, val, $urandom_range(0, 16));
               default: queue_cmd(CMD_DELETE_AT, val,
                                  (plan_fill == 0 || $urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, 16) : $urandom_range(1, plan_fill));
            endcase
         end
      end
      total = pending_cmds.size();

      // Reset, then let the driver run
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cmds < total || expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
tb/sv/positional_ordered_list_tb.sv
